>>> rtl/plk_pkg.sv
// Shared types and constants for the positional list engine.
package plk_pkg;

	localparam int PLK_CAPACITY = 64;
	localparam int DATA_W = 32;
	localparam int POS_W = 7;

	typedef enum logic [1:0] {
		FN_GET    = 2'd0,
		FN_LOCATE = 2'd1,
		FN_INSERT = 2'd2,
		FN_DELETE = 2'd3
	} plk_func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_POS   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} plk_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN
	} plk_state_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic              get;
		logic              locate;
		logic              ins;
		logic              del;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] key;
	} plk_cmd_t;

	// Search token that travels down the row one cell per cycle.
	typedef struct packed {
		logic              valid;
		logic              found;
		logic [DATA_W-1:0] data;
		logic [POS_W-1:0]  pos;
	} plk_scan_t;

endpackage

>>> rtl/positional_list_engine_unit.sv
// Top level of the positional list engine: controller, length register and the row of cells.
// Insert and delete shift the cells in the execute state, and the result strobe is registered
// from it. Get and locate send a search token down the row of CAPACITY cells, one cell per
// cycle, and their result is strobed once the token leaves the last cell.
// busy is high from the cycle after a request until its result is strobed; a new request is
// taken in the strobe cycle. The receiver cannot stall. Reset clears the length and control.
module positional_list_engine_unit #(
	parameter int CAPACITY = plk_pkg::PLK_CAPACITY
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          func,
	input  logic [6:0]          position,
	input  logic signed [31:0]  value,
	output logic                done,
	output logic [1:0]          status,
	output logic signed [31:0]  read_value,
	output logic [6:0]          found_position,
	output logic [6:0]          length
);
	import plk_pkg::*;

	// The length register must hold every count from zero up to the capacity.
	localparam int LEN_W = $clog2(CAPACITY + 1);
	// Comparison width wide enough for both the position and the length plus one.
	localparam int CW = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

	plk_state_t state_q;
	plk_state_t state_d;

	// Request captured at acceptance; it stays put until the result is strobed.
	plk_func_t         func_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] key_q;
	logic [LEN_W-1:0]  len_q;

	logic              done_q;
	plk_status_t       status_q;
	logic [DATA_W-1:0] read_value_q;
	logic [POS_W-1:0]  found_pos_q;

	plk_cmd_t          cmd;
	logic              scan_inject;
	logic              is_search;
	logic              accept;

	logic [CW-1:0]     pos_x;
	logic [CW-1:0]     len_x;
	logic              pos_zero;
	logic              ins_bad;
	logic              del_bad;
	logic              list_full;

	logic [DATA_W-1:0] cell_data [CAPACITY];
	plk_scan_t         scan_chain [CAPACITY+1];
	plk_scan_t         scan_tail;

	assign accept    = start && !busy;
	assign is_search = (func_q == FN_GET) || (func_q == FN_LOCATE);

	// Range checks for insert and delete. An insert may append just past the end;
	// a delete must name an existing element. Bad position is checked before full.
	assign pos_x     = CW'(pos_q);
	assign len_x     = CW'(len_q);
	assign pos_zero  = (pos_q == '0);
	assign ins_bad   = pos_zero || (pos_x > (len_x + CW'(1)));
	assign del_bad   = pos_zero || (pos_x > len_x);
	assign list_full = (len_x == CW'(CAPACITY));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = is_search ? S_SCAN : S_IDLE;
			end
			S_SCAN: begin
				if (scan_tail.valid) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Controller outputs: busy, the broadcast command and the token launch.
	always_comb begin
		busy        = 1'b0;
		scan_inject = 1'b0;
		cmd.get     = (func_q == FN_GET);
		cmd.locate  = (func_q == FN_LOCATE);
		cmd.ins     = 1'b0;
		cmd.del     = 1'b0;
		cmd.pos     = pos_q;
		cmd.key     = key_q;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
			end
			S_EXEC: begin
				busy        = 1'b1;
				scan_inject = is_search;
				cmd.ins     = (func_q == FN_INSERT) && !ins_bad && !list_full;
				cmd.del     = (func_q == FN_DELETE) && !del_bad;
			end
			S_SCAN: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == S_EXEC) && !is_search) ||
			           ((state_q == S_SCAN) && scan_tail.valid);
			if (cmd.ins) begin
				len_q <= len_q + LEN_W'(1);
			end else if (cmd.del) begin
				len_q <= len_q - LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= plk_func_t'(func);
			pos_q  <= position;
			key_q  <= value;
		end
	end

	// Result registers. Shifting operations finish in the execute cycle; searches
	// finish when the token leaves the last cell.
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && !is_search) begin
			read_value_q <= '0;
			found_pos_q  <= '0;
			if (func_q == FN_INSERT) begin
				status_q <= ins_bad ? ST_BAD_POS : (list_full ? ST_FULL : ST_OK);
			end else begin
				status_q <= del_bad ? ST_BAD_POS : ST_OK;
			end
		end else if (state_q == S_SCAN && scan_tail.valid) begin
			if (scan_tail.found) begin
				status_q     <= ST_OK;
				read_value_q <= (func_q == FN_GET) ? scan_tail.data : '0;
				found_pos_q  <= (func_q == FN_LOCATE) ? scan_tail.pos : '0;
			end else begin
				status_q     <= (func_q == FN_GET) ? ST_BAD_POS : ST_NOT_FOUND;
				read_value_q <= '0;
				found_pos_q  <= '0;
			end
		end
	end

	// The token enters the first cell empty; each cell either claims it or passes it on.
	assign scan_chain[0] = {scan_inject, 1'b0, DATA_W'(0), POS_W'(0)};
	assign scan_tail     = scan_chain[CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_nb;
		logic [DATA_W-1:0] right_nb;

		// The first cell has no left neighbor and the last has no right neighbor.
		if (i == 0) begin : g_first
			assign left_nb = key_q;
		end else begin : g_mid_l
			assign left_nb = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_nb = cell_data[i];
		end else begin : g_mid_r
			assign right_nb = cell_data[i+1];
		end

		plk_cell #(
			.IDX   (i),
			.LEN_W (LEN_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.len        (len_q),
			.left_data  (left_nb),
			.right_data (right_nb),
			.data       (cell_data[i]),
			.scan_in    (scan_chain[i]),
			.scan_out   (scan_chain[i+1])
		);
	end

	assign done           = done_q;
	assign status         = status_q;
	assign read_value     = read_value_q;
	assign found_position = found_pos_q;
	assign length         = 7'(len_q);

`ifndef SYNTHESIS
	// The list never holds more elements than there are cells.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(len_q) <= CW'(CAPACITY))
		else $error("list length exceeds capacity");

	// A result only follows work in the execute or search state.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == S_EXEC) || ($past(state_q) == S_SCAN))
		else $error("result strobed without a request in flight");

	// The search token only leaves the row while the controller waits for it.
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_tail.valid |-> (state_q == S_SCAN))
		else $error("search token arrived outside the search state");

	// A full status is given only when every cell is occupied.
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == ST_FULL)) |-> (CW'(len_q) == CW'(CAPACITY)))
		else $error("full status with free cells");

	// Shifts change the length by exactly one; this property checks the insert.
	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> (len_q == $past(len_q) + LEN_W'(1)))
		else $error("insert did not grow the list by one");
`endif

endmodule

>>> rtl/plk_cell.sv
// One storage cell of the list: holds one element and one stage of the search token.
module plk_cell #(
	parameter int IDX   = 0,
	parameter int LEN_W = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  plk_pkg::plk_cmd_t        cmd,
	input  logic [LEN_W-1:0]         len,
	input  logic [plk_pkg::DATA_W-1:0] left_data,
	input  logic [plk_pkg::DATA_W-1:0] right_data,
	output logic [plk_pkg::DATA_W-1:0] data,
	input  plk_pkg::plk_scan_t       scan_in,
	output plk_pkg::plk_scan_t       scan_out
);
	import plk_pkg::*;

	// 1-based position that this cell represents.
	localparam logic [31:0] RANK = 32'(IDX + 1);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;
	logic              tok_valid_q;
	logic              tok_found_q;
	logic [DATA_W-1:0] tok_data_q;
	logic [POS_W-1:0]  tok_pos_q;
	logic              in_range;
	logic              hit;
	logic [31:0]       pos_x;

	assign pos_x    = 32'(cmd.pos);
	assign in_range = (RANK <= 32'(len));
	assign hit      = in_range && ((cmd.get && (pos_x == RANK)) ||
	                              (cmd.locate && (data_q == cmd.key)));

	// Insert moves cells at and above the position up by one; delete moves them down.
	always_comb begin
		data_d = data_q;
		if (cmd.ins) begin
			if (RANK > pos_x) begin
				data_d = left_data;
			end else if (RANK == pos_x) begin
				data_d = cmd.key;
			end
		end else if (cmd.del) begin
			if (RANK >= pos_x) begin
				data_d = right_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= scan_in.valid;
		end
	end

	// The first hit along the row wins; later cells pass the token on untouched.
	always_ff @(posedge clk) begin
		if (scan_in.found || !hit) begin
			tok_found_q <= scan_in.found;
			tok_data_q  <= scan_in.data;
			tok_pos_q   <= scan_in.pos;
		end else begin
			tok_found_q <= 1'b1;
			tok_data_q  <= data_q;
			tok_pos_q   <= POS_W'(RANK);
		end
	end

	assign data     = data_q;
	assign scan_out = {tok_valid_q, tok_found_q, tok_data_q, tok_pos_q};

endmodule
